// ===== design/spb_pkg.sv =====
// Shared types for the sequence pair builder: item structs, sequencer codes
// and the control group of the order store. No dependencies.
package spb_pkg;

  // Results carry at most this many positions.
  localparam int unsigned EmitCap = 32;
  localparam int unsigned PosW    = 5;

  typedef struct packed {
    logic [7:0]  module_id;
    logic [15:0] left_x;
    logic [15:0] right_x;
    logic [15:0] low_y;
    logic [15:0] high_y;
    logic        start_req;
    logic        finish;
  } spb_in_t;

  typedef struct packed {
    logic [PosW-1:0] position;
    logic [7:0]      first_seq_id;
    logic [7:0]      second_seq_id;
    logic            last_entry;
    logic            overflowed;
  } spb_out_t;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_FIND   = 9'b000000010,
    S_SNAP   = 9'b000000100,
    S_CMP    = 9'b000001000,
    S_LOC    = 9'b000010000,
    S_SHIFT  = 9'b000100000,
    S_PUT    = 9'b001000000,
    S_EMIT_A = 9'b010000000,
    S_EMIT_B = 9'b100000000
  } spb_state_e;

  // Kind of edit applied to one sequence.
  typedef enum logic [1:0] {
    M_INS = 2'd0,
    M_MVL = 2'd1,
    M_MVR = 2'd2
  } spb_mode_e;

  // Control of the order store: which sequence is read, which are written.
  typedef struct packed {
    logic rd_sel_b;
    logic we_a;
    logic we_b;
  } spb_ord_ctrl_t;

endpackage

// ===== design/sequence_pair_builder_core.sv =====
// Top level of the sequence pair builder: sequencer, module tables and the
// result register. Depends on spb_pkg and spb_order_store.
//
//  Channel  | Ports                   | Handshake
//  ---------+-------------------------+------------------------------------
//  item in  | start, busy, in_i       | transfer when start && !busy
//  result   | valid_o, res_o          | one-cycle strobe, no back pressure
//
// A start item seeds both sequences. Other items take a scan of the id
// table, a snapshot of sequence A, then for each held module and each
// sequence a position scan plus any shift steps and one write, all through
// the one order store port. A finish then emits each position through the
// emit states A and B.
// Reset clears the state, the module count, the drop flag and the result strobe; no clearing pass.
// Results cannot be stalled; a new item may be taken while the last result shows.
module sequence_pair_builder_core #(
  parameter int unsigned MAX_MODULES = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  spb_pkg::spb_in_t   in_i,
  output logic               valid_o,
  output spb_pkg::spb_out_t  res_o
);
  import spb_pkg::*;

  localparam int unsigned SW = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1;
  localparam int unsigned CW = $clog2(MAX_MODULES + 1);

  spb_state_e state_q, state_d;
  spb_mode_e  mode_q, mode_d;
  spb_in_t    item_q;
  logic [CW-1:0] count_q, count_d, before_q, before_d, len_a_q, len_a_d, len_b_q, len_b_d;
  logic          drop_q, drop_d;
  logic [SW-1:0] slot_q, slot_d, k_q, k_d, j_q, j_d, at_q, at_d, sp_q, sp_d;
  logic [SW-1:0] psp_q, psp_d, pmm_q, pmm_d;
  logic          psp_hit_q, psp_hit_d, pmm_hit_q, pmm_hit_d;
  logic          left_a_q, left_a_d, left_b_q, left_b_d, sel_b_q, sel_b_d;
  logic [7:0]    id_a_q, id_a_d;
  logic          valid_q, valid_d;
  spb_out_t      res_q, res_d;

  // Module tables.
  logic [7:0]    ids_mem  [MAX_MODULES];
  logic [47:0]   rect_mem [MAX_MODULES];
  logic [SW-1:0] snap_mem [MAX_MODULES];

  logic          ids_we, rect_we, snap_we;
  logic [SW-1:0] ids_waddr, rect_waddr, ids_raddr;
  logic [7:0]    ids_wdata, ids_rd;
  logic [47:0]   rect_wdata, rect_rd;
  logic [SW-1:0] snap_rd;

  spb_ord_ctrl_t ord_ctrl;
  logic [SW-1:0] ord_raddr, ord_waddr, ord_wdata, ord_rdata;

  logic [CW-1:0] len_cur, emit_n;
  logic          left_cur, go_next, go_done, accept;

  assign accept  = start && !busy;
  assign busy    = (state_q != S_IDLE);
  assign valid_o = valid_q;
  assign res_o   = res_q;

  assign ids_rd  = ids_mem[ids_raddr];
  assign snap_rd = snap_mem[k_q];
  assign rect_rd = rect_mem[snap_rd];

  assign len_cur  = sel_b_q ? len_b_q : len_a_q;
  assign left_cur = sel_b_q ? left_b_q : left_a_q;
  assign emit_n   = ((MAX_MODULES > EmitCap) && (count_q > CW'(EmitCap))) ?
                    CW'(EmitCap) : count_q;

  spb_order_store #(
    .Depth(MAX_MODULES),
    .SlotW(SW)
  ) u_order (
    .clk_i  (clk_i),
    .ctrl_i (ord_ctrl),
    .raddr_i(ord_raddr),
    .waddr_i(ord_waddr),
    .wdata_i(ord_wdata),
    .rdata_o(ord_rdata)
  );

  // Sequencer: drives the module tables and the order store from the current state.
  always_comb begin
    logic          hit_sp, hit_mm, p_hit, m_hit;
    logic [SW-1:0] p_pos, m_pos, at_v;
    state_d = state_q; mode_d = mode_q; count_d = count_q; before_d = before_q;
    len_a_d = len_a_q; len_b_d = len_b_q; drop_d = drop_q; slot_d = slot_q;
    k_d = k_q; j_d = j_q; at_d = at_q; sp_d = sp_q; psp_d = psp_q; pmm_d = pmm_q;
    psp_hit_d = psp_hit_q; pmm_hit_d = pmm_hit_q; left_a_d = left_a_q;
    left_b_d = left_b_q; sel_b_d = sel_b_q; id_a_d = id_a_q;
    valid_d = 1'b0; res_d = res_q;
    ids_we = 1'b0; ids_waddr = '0; ids_wdata = item_q.module_id; ids_raddr = k_q;
    rect_we = 1'b0; rect_waddr = slot_q;
    rect_wdata = {item_q.high_y, item_q.low_y, item_q.right_x};
    snap_we = 1'b0;
    ord_ctrl = '0; ord_ctrl.rd_sel_b = sel_b_q;
    ord_raddr = j_q; ord_waddr = j_q; ord_wdata = ord_rdata;
    go_next = 1'b0; go_done = 1'b0;
    hit_sp = 1'b0; hit_mm = 1'b0; p_hit = 1'b0; m_hit = 1'b0;
    p_pos = '0; m_pos = '0; at_v = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          before_d = count_q; len_a_d = count_q; len_b_d = count_q;
          k_d = '0;
          if (in_i.start_req || count_q == '0) begin
            // Seed both sequences with this module alone.
            ids_we = 1'b1; ids_waddr = '0; ids_wdata = in_i.module_id;
            rect_we = 1'b1; rect_waddr = '0;
            rect_wdata = {in_i.high_y, in_i.low_y, in_i.right_x};
            ord_ctrl.we_a = 1'b1; ord_ctrl.we_b = 1'b1;
            ord_waddr = '0; ord_wdata = '0;
            count_d = CW'(1); drop_d = 1'b0;
            state_d = in_i.finish ? S_EMIT_A : S_IDLE;
          end else begin
            slot_d  = count_q[SW-1:0];
            state_d = S_FIND;
          end
        end
      end
      S_FIND: begin
        // Look for the id among the held modules.
        if (ids_rd == item_q.module_id) begin
          slot_d = k_q; k_d = '0; state_d = S_SNAP;
        end else if (CW'(k_q) == count_q - CW'(1)) begin
          k_d = '0;
          if (count_q >= CW'(MAX_MODULES)) begin
            drop_d = 1'b1;
            go_done = 1'b1;
          end else begin
            ids_we = 1'b1; ids_waddr = count_q[SW-1:0];
            rect_we = 1'b1; rect_waddr = count_q[SW-1:0];
            slot_d = count_q[SW-1:0];
            count_d = count_q + CW'(1);
            state_d = S_SNAP;
          end
        end else begin
          k_d = k_q + SW'(1);
        end
      end
      S_SNAP: begin
        // Copy sequence A as it stood when the item arrived.
        ord_ctrl.rd_sel_b = 1'b0; ord_raddr = k_q; snap_we = 1'b1;
        if (CW'(k_q) == before_q - CW'(1)) begin
          k_d = '0; state_d = S_CMP;
        end else begin
          k_d = k_q + SW'(1);
        end
      end
      S_CMP: begin
        // Direction rule against the stored rectangle of this module.
        sp_d = snap_rd;
        left_a_d = (item_q.left_x < rect_rd[15:0]) && (rect_rd[47:32] < item_q.low_y);
        left_b_d = (item_q.left_x < rect_rd[15:0]) && (item_q.high_y < rect_rd[31:16]);
        sel_b_d = 1'b0; j_d = '0; psp_hit_d = 1'b0; pmm_hit_d = 1'b0;
        state_d = S_LOC;
      end
      S_LOC: begin
        // Find both modules in the current sequence.
        hit_sp = (ord_rdata == sp_q);
        hit_mm = (ord_rdata == slot_q);
        p_hit = psp_hit_q || hit_sp; p_pos = hit_sp ? j_q : psp_q;
        m_hit = pmm_hit_q || hit_mm; m_pos = hit_mm ? j_q : pmm_q;
        psp_hit_d = p_hit; psp_d = p_pos; pmm_hit_d = m_hit; pmm_d = m_pos;
        if (CW'(j_q) == len_cur - CW'(1)) begin
          if (!p_hit) begin
            go_next = 1'b1;
          end else if (!m_hit) begin
            if (len_cur >= CW'(MAX_MODULES)) begin
              go_next = 1'b1;
            end else begin
              at_v = left_cur ? p_pos : p_pos + SW'(1);
              at_d = at_v; mode_d = M_INS;
              if (CW'(at_v) == len_cur) begin
                state_d = S_PUT;
              end else begin
                j_d = SW'(len_cur - CW'(1)); state_d = S_SHIFT;
              end
            end
          end else if (left_cur && m_pos > p_pos) begin
            at_d = p_pos; mode_d = M_MVL; j_d = m_pos; state_d = S_SHIFT;
          end else if (!left_cur && m_pos < p_pos) begin
            at_d = p_pos; mode_d = M_MVR; j_d = m_pos; state_d = S_SHIFT;
          end else begin
            go_next = 1'b1;
          end
        end else begin
          j_d = j_q + SW'(1);
        end
      end
      S_SHIFT: begin
        // Move one entry per cycle to open or close a gap.
        ord_ctrl.we_a = !sel_b_q; ord_ctrl.we_b = sel_b_q;
        case (mode_q)
          M_INS: begin
            ord_raddr = j_q; ord_waddr = j_q + SW'(1);
            if (j_q == at_q) state_d = S_PUT;
            else j_d = j_q - SW'(1);
          end
          M_MVL: begin
            ord_raddr = j_q - SW'(1); ord_waddr = j_q;
            if (j_q == at_q + SW'(1)) state_d = S_PUT;
            else j_d = j_q - SW'(1);
          end
          M_MVR: begin
            ord_raddr = j_q + SW'(1); ord_waddr = j_q;
            if (j_q + SW'(1) == at_q) state_d = S_PUT;
            else j_d = j_q + SW'(1);
          end
          default: begin
            state_d = S_PUT;
          end
        endcase
      end
      S_PUT: begin
        // Drop the module into its place.
        ord_ctrl.we_a = !sel_b_q; ord_ctrl.we_b = sel_b_q;
        ord_waddr = at_q; ord_wdata = slot_q;
        if (mode_q == M_INS) begin
          if (sel_b_q) len_b_d = len_b_q + CW'(1);
          else len_a_d = len_a_q + CW'(1);
        end else if (!sel_b_q) begin
          rect_we = 1'b1; rect_waddr = slot_q;
        end
        go_next = 1'b1;
      end
      S_EMIT_A: begin
        ord_ctrl.rd_sel_b = 1'b0; ord_raddr = k_q; ids_raddr = ord_rdata;
        id_a_d = ids_rd; state_d = S_EMIT_B;
      end
      S_EMIT_B: begin
        ord_ctrl.rd_sel_b = 1'b1; ord_raddr = k_q; ids_raddr = ord_rdata;
        valid_d = 1'b1;
        res_d.position = PosW'(k_q);
        res_d.first_seq_id = id_a_q;
        res_d.second_seq_id = ids_rd;
        res_d.last_entry = (CW'(k_q) == emit_n - CW'(1));
        res_d.overflowed = drop_q;
        if (CW'(k_q) == emit_n - CW'(1)) begin
          state_d = S_IDLE;
        end else begin
          k_d = k_q + SW'(1); state_d = S_EMIT_A;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Advance to sequence B, then to the next held module.
    if (go_next) begin
      j_d = '0; psp_hit_d = 1'b0; pmm_hit_d = 1'b0;
      if (!sel_b_q) begin
        sel_b_d = 1'b1; state_d = S_LOC;
      end else if (CW'(k_q) == before_q - CW'(1)) begin
        go_done = 1'b1;
      end else begin
        k_d = k_q + SW'(1); state_d = S_CMP;
      end
    end
    if (go_done) begin
      k_d = '0;
      state_d = item_q.finish ? S_EMIT_A : S_IDLE;
    end
  end

  // Table writes.
  always_ff @(posedge clk_i) begin
    if (ids_we) ids_mem[ids_waddr] <= ids_wdata;
    if (rect_we) rect_mem[rect_waddr] <= rect_wdata;
    if (snap_we) snap_mem[k_q] <= ord_rdata;
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_i;
    mode_q <= mode_d; before_q <= before_d; len_a_q <= len_a_d; len_b_q <= len_b_d;
    slot_q <= slot_d; k_q <= k_d; j_q <= j_d; at_q <= at_d; sp_q <= sp_d;
    psp_q <= psp_d; pmm_q <= pmm_d; psp_hit_q <= psp_hit_d; pmm_hit_q <= pmm_hit_d;
    left_a_q <= left_a_d; left_b_q <= left_b_d; sel_b_q <= sel_b_d;
    id_a_q <= id_a_d; res_q <= res_d;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      drop_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      drop_q  <= drop_d;
      valid_q <= valid_d;
    end
  end

  // A result strobe only follows the second emit step.
  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(state_q == S_EMIT_B))
    else $error("result strobe without emit step");

  // The last position of a run is never followed by another result.
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && res_o.last_entry |=> !valid_o)
    else $error("result after last entry");

  // The module count stays within capacity.
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_MODULES))
    else $error("module count beyond capacity");

  // Sequencing states never run with an empty table.
  a_count_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOC || state_q == S_EMIT_B) |-> count_q != '0)
    else $error("sequencing with no modules held");

endmodule

// ===== design/spb_order_store.sv =====
// Storage for both sequences (slot numbers per position), one read port and
// one shared write port. Depends on spb_pkg.
module spb_order_store #(
  parameter int unsigned Depth = 32,
  parameter int unsigned SlotW = 5
) (
  input  logic                  clk_i,
  input  spb_pkg::spb_ord_ctrl_t ctrl_i,
  input  logic [SlotW-1:0]      raddr_i,
  input  logic [SlotW-1:0]      waddr_i,
  input  logic [SlotW-1:0]      wdata_i,
  output logic [SlotW-1:0]      rdata_o
);
  import spb_pkg::*;

  logic [SlotW-1:0] seq_a_q [Depth];
  logic [SlotW-1:0] seq_b_q [Depth];

  // Read the selected sequence at one address.
  assign rdata_o = ctrl_i.rd_sel_b ? seq_b_q[raddr_i] : seq_a_q[raddr_i];

  // Writes go to either or both sequences at one address.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.we_a) begin
      seq_a_q[waddr_i] <= wdata_i;
    end
    if (ctrl_i.we_b) begin
      seq_b_q[waddr_i] <= wdata_i;
    end
  end

endmodule
